/* sv/utf8_text_validator_defines.svh */
// Assertion macros for the UTF-8 text validator.
`ifndef UTF8_TEXT_VALIDATOR_DEFINES_SVH
`define UTF8_TEXT_VALIDATOR_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset.
`define UTV_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("utf8_text_validator: check failed");

// Next-cycle implication, disabled during reset.
`define UTV_ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("utf8_text_validator: check failed");

`else

`define UTV_ASSERT_IMP(lbl, clk, rst, pre, post)
`define UTV_ASSERT_NXT(lbl, clk, rst, pre, post)

`endif

`endif

/* sv/utv_pkg.sv */
`default_nettype none

package utv_pkg;

   localparam int unsigned LenWidth = 8;
   localparam int unsigned SeenWidth = 9;
   localparam int unsigned CpWidth = 21;

   localparam logic [LenWidth-1:0] MaxLengthReset = 8'd48;

   // Minimum code point class of an open sequence
   localparam logic [1:0] ClassNone = 2'd0;
   localparam logic [1:0] ClassTwo = 2'd1;
   localparam logic [1:0] ClassThree = 2'd2;
   localparam logic [1:0] ClassFour = 2'd3;

   typedef struct packed {
      logic [1:0]           pending;
      logic [CpWidth-1:0]   code_point;
      logic [1:0]           min_class;
      logic [SeenWidth-1:0] bytes_seen;
      logic                 failed;
   } utv_state_type;

endpackage

`default_nettype wire

/* sv/utv_if.sv */
`default_nettype none

// Request channel: at most one text byte per request
interface utv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       byte_present;
   logic       last_item;

   modport source (output valid, output text_byte, output byte_present,
                   output last_item, input ready);
   modport sink (input valid, input text_byte, input byte_present,
                 input last_item, output ready);
endinterface

// Response channel: one verdict per text
interface utv_rsp_if;
   logic valid;
   logic ready;
   logic accepted;

   modport source (output valid, output accepted, input ready);
   modport sink (input valid, input accepted, output ready);
endinterface

// Register write channel for the length bound
interface utv_csr_if;
   logic                           valid;
   logic                           ready;
   logic [utv_pkg::LenWidth-1:0]   max_length;

   modport source (output valid, output max_length, input ready);
   modport sink (input valid, input max_length, output ready);
endinterface

`default_nettype wire

/* sv/utv_step.sv */
`default_nettype none

module utv_step (
   input  wire utv_pkg::utv_state_type        cur_state,
   input  wire logic [7:0]                    text_byte,
   input  wire logic                          byte_present,
   input  wire logic                          last_item,
   input  wire logic [utv_pkg::LenWidth-1:0]  max_length,
   output utv_pkg::utv_state_type             next_state,
   output logic                               accepted
);

   localparam logic [7:0] LeadTwoLo = 8'hC2;
   localparam logic [7:0] LeadTwoHi = 8'hDF;
   localparam logic [7:0] LeadThreeLo = 8'hE0;
   localparam logic [7:0] LeadThreeHi = 8'hEF;
   localparam logic [7:0] LeadFourLo = 8'hF0;
   localparam logic [7:0] LeadFourHi = 8'hF4;
   localparam logic [utv_pkg::SeenWidth-1:0] SeenMax = '1;

   // Range checks on a finished code point
   function automatic logic code_point_ok(input logic [utv_pkg::CpWidth-1:0] c,
                                          input logic [1:0] cls);
      logic [utv_pkg::CpWidth-1:0] min_cp;
      logic                        ok;
      case (cls)
         utv_pkg::ClassNone:  min_cp = 21'h0;
         utv_pkg::ClassTwo:   min_cp = 21'h80;
         utv_pkg::ClassThree: min_cp = 21'h800;
         utv_pkg::ClassFour:  min_cp = 21'h10000;
         default:             min_cp = 21'h0;
      endcase
      ok = 1'b1;
      if (c < min_cp) ok = 1'b0;
      if (c > 21'h10FFFF) ok = 1'b0;
      if (c >= 21'hD800 && c <= 21'hDFFF) ok = 1'b0;
      if (c < 21'h20) ok = 1'b0;
      if (c >= 21'h7F && c <= 21'h9F) ok = 1'b0;
      if (c == 21'h2028 || c == 21'h2029) ok = 1'b0;
      return ok;
   endfunction

   logic [utv_pkg::CpWidth-1:0] cp_shift;
   logic [1:0]                  pending_dec;

   assign cp_shift = {cur_state.code_point[utv_pkg::CpWidth-7:0], text_byte[5:0]};
   assign pending_dec = cur_state.pending - 2'd1;

   // Count, decode one byte, then close the text on the last request
   always_comb begin
      next_state = cur_state;
      if (byte_present) begin
         if (cur_state.bytes_seen != SeenMax) begin
            next_state.bytes_seen = cur_state.bytes_seen + 9'd1;
         end
         if (next_state.bytes_seen > {1'b0, max_length}) begin
            next_state.failed = 1'b1;
         end
         if (!next_state.failed) begin
            if (cur_state.pending == 2'd0) begin
               if (!text_byte[7]) begin
                  if (!code_point_ok({13'd0, text_byte}, utv_pkg::ClassNone)) begin
                     next_state.failed = 1'b1;
                  end
               end else if (text_byte >= LeadTwoLo && text_byte <= LeadTwoHi) begin
                  next_state.code_point = {16'd0, text_byte[4:0]};
                  next_state.pending = 2'd1;
                  next_state.min_class = utv_pkg::ClassTwo;
               end else if (text_byte >= LeadThreeLo && text_byte <= LeadThreeHi) begin
                  next_state.code_point = {17'd0, text_byte[3:0]};
                  next_state.pending = 2'd2;
                  next_state.min_class = utv_pkg::ClassThree;
               end else if (text_byte >= LeadFourLo && text_byte <= LeadFourHi) begin
                  next_state.code_point = {18'd0, text_byte[2:0]};
                  next_state.pending = 2'd3;
                  next_state.min_class = utv_pkg::ClassFour;
               end else begin
                  next_state.failed = 1'b1;
               end
            end else if (text_byte[7:6] != 2'b10) begin
               next_state.failed = 1'b1;
            end else begin
               next_state.pending = pending_dec;
               if (pending_dec == 2'd0) begin
                  if (!code_point_ok(cp_shift, cur_state.min_class)) begin
                     next_state.failed = 1'b1;
                  end
                  next_state.code_point = '0;
                  next_state.min_class = utv_pkg::ClassNone;
               end else begin
                  next_state.code_point = cp_shift;
               end
            end
         end
      end
      // An open sequence at the end is truncated
      accepted = !(next_state.failed || next_state.pending != 2'd0);
      if (last_item) begin
         next_state = '0;
      end
   end

endmodule

`default_nettype wire

/* sv/utf8_text_validator.sv */
// A last request's verdict is formed from the input stage into the response register.
// Throughput: one byte per cycle; the input stage holds a last request only while
// the response register still holds an untaken verdict.
// Reset (synchronous, active high) clears the text state and both valid flags,
// and sets the length bound to 48.
`default_nettype none
`include "utf8_text_validator_defines.svh"

module utf8_text_validator (
   input wire logic  clock,
   input wire logic  reset,
   utv_req_if.sink   req_bus,
   utv_rsp_if.source rsp_bus,
   utv_csr_if.sink   csr_bus
);

   logic                          in_valid_ff;
   logic                          in_valid_in;
   logic [7:0]                    in_byte_ff;
   logic                          in_present_ff;
   logic                          in_last_ff;
   logic                          in_stall;
   logic                          in_fire;
   logic                          req_take;
   utv_pkg::utv_state_type        state_ff;
   utv_pkg::utv_state_type        state_in;
   utv_pkg::utv_state_type        step_state;
   logic                          step_accepted;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic                          rsp_accepted_ff;
   logic [utv_pkg::LenWidth-1:0]  max_length_ff;

   // Hold a last request while the verdict register is still occupied
   assign in_stall = in_valid_ff && in_last_ff && rsp_valid_ff && !rsp_bus.ready;
   assign in_fire = in_valid_ff && !in_stall;
   assign req_bus.ready = !in_stall;
   assign req_take = req_bus.valid && req_bus.ready;
   assign in_valid_in = req_take ? 1'b1 : (in_fire ? 1'b0 : in_valid_ff);

   assign csr_bus.ready = 1'b1;

   utv_step u_step (
      .cur_state    (state_ff),
      .text_byte    (in_byte_ff),
      .byte_present (in_present_ff),
      .last_item    (in_last_ff),
      .max_length   (max_length_ff),
      .next_state   (step_state),
      .accepted     (step_accepted)
   );

   // Advance state only on a processed request
   assign state_in = in_fire ? step_state : state_ff;
   assign rsp_valid_in = (in_fire && in_last_ff) ? 1'b1
                       : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.accepted = rsp_accepted_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff <= '0;
         rsp_valid_ff <= 1'b0;
         max_length_ff <= utv_pkg::MaxLengthReset;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) begin
            max_length_ff <= csr_bus.max_length;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_bus.text_byte;
         in_present_ff <= req_bus.byte_present;
         in_last_ff <= req_bus.last_item;
      end
      if (in_fire && in_last_ff) begin
         rsp_accepted_ff <= step_accepted;
      end
   end

   // An open sequence never has more continuations left than its lead announced
   `UTV_ASSERT_IMP(a_pending_class, clock, reset, state_ff.pending != 2'd0,
                   state_ff.min_class >= state_ff.pending)
   // With no open sequence, the partial code point and class are clear
   `UTV_ASSERT_IMP(a_idle_clean, clock, reset, state_ff.pending == 2'd0,
                   state_ff.code_point == '0 && state_ff.min_class == utv_pkg::ClassNone)
   // Closing a text returns the state to its reset value and posts a verdict
   `UTV_ASSERT_NXT(a_last_clears, clock, reset, in_fire && in_last_ff,
                   state_ff == '0 && rsp_valid_ff)

endmodule

`default_nettype wire
